// ----- design/sktl_pkg.sv -----
package sktl_pkg;

  localparam int KEY_W    = 63;
  localparam int POS_W    = 10;
  localparam int ENT_W    = 11;
  localparam int TREE_FAN = 8;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WAIT = 3'b010,
    S_FIN  = 3'b100
  } state_t;

endpackage

// ----- design/sktl_cell.sv -----
module sktl_cell #(
  parameter int IDX = 0,
  parameter int CW  = 11
) (
  input  logic                     clk,
  input  logic                     ins,
  input  logic [sktl_pkg::KEY_W-1:0] key,
  input  logic [CW-1:0]            count,
  input  logic [sktl_pkg::KEY_W-1:0] prev_key,
  input  logic                     prev_lt,
  output logic [sktl_pkg::KEY_W-1:0] key_q,
  output logic                     lt_q,
  output logic                     eq_q
);
  import sktl_pkg::*;

  logic [KEY_W-1:0] key_r;
  logic             lt_r;
  logic             eq_r;
  logic             occ;

  assign occ = CW'(IDX) < count;

  always_ff @(posedge clk) begin
    lt_r <= occ && (key_r < key);
    eq_r <= occ && (key_r == key);
    // cells below the insert point keep their key; the boundary cell takes
    // the new key, everything above takes its lower neighbor's key
    if (ins && !lt_r) begin
      key_r <= prev_lt ? key : prev_key;
    end
  end

  assign key_q = key_r;
  assign lt_q  = lt_r;
  assign eq_q  = eq_r;

endmodule

// ----- design/sktl_tree.sv -----
module sktl_tree #(
  parameter int N  = 1024,
  parameter int LV = 4,
  parameter int CW = 11
) (
  input  logic          clk,
  input  logic [N-1:0]  lt,
  input  logic [N-1:0]  eq,
  output logic [CW-1:0] sum,
  output logic          hit
);
  import sktl_pkg::*;

  localparam int PN  = TREE_FAN ** LV;
  localparam int TOT = (PN - 1) / (TREE_FAN - 1);

  logic [PN-1:0] lt_pad;
  logic [PN-1:0] eq_pad;
  logic [CW-1:0] sum_r [TOT];
  logic          hit_r [TOT];

  assign lt_pad = PN'(lt);
  assign eq_pad = PN'(eq);

  // node array holds all levels back to back, leaves' parents first
  for (genvar l = 0; l < LV; l++) begin : g_lvl
    localparam int NODES = PN / (TREE_FAN ** (l + 1));
    localparam int OFF   = (PN - TREE_FAN ** (LV - l)) / (TREE_FAN - 1);
    for (genvar j = 0; j < NODES; j++) begin : g_node
      logic [CW-1:0] acc;
      logic          any;
      if (l == 0) begin : g_leaf
        always_comb begin
          acc = '0;
          any = 1'b0;
          for (int c = 0; c < TREE_FAN; c++) begin
            acc = acc + CW'(lt_pad[j*TREE_FAN + c]);
            any = any | eq_pad[j*TREE_FAN + c];
          end
        end
      end else begin : g_inner
        localparam int COFF = (PN - TREE_FAN ** (LV - l + 1)) / (TREE_FAN - 1);
        always_comb begin
          acc = '0;
          any = 1'b0;
          for (int c = 0; c < TREE_FAN; c++) begin
            acc = acc + sum_r[COFF + j*TREE_FAN + c];
            any = any | hit_r[COFF + j*TREE_FAN + c];
          end
        end
      end
      always_ff @(posedge clk) begin
        sum_r[OFF + j] <= acc;
        hit_r[OFF + j] <= any;
      end
    end
  end

  assign sum = sum_r[TOT-1];
  assign hit = hit_r[TOT-1];

endmodule

// ----- design/sorted_key_table_lookup_insert.sv -----
// Flow: a key is registered and compared in the cell row, and a registered 8-way
// count/match tree of LV = ceil(log2(TABLE_DEPTH) / 3) levels (4 at 1024) turns
// the per-cell flags into a position. One key at a time: in_ready is low from accept
// until the result word is issued, which waits for out_ready while a result is held.
// Reset: synchronous, active low; clears the entry count, FSM and output valid.
// Key storage is not cleared; cells at or above the entry count are ignored.
module sorted_key_table_lookup_insert #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [sktl_pkg::KEY_W-1:0] in_key,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_found,
  output logic [sktl_pkg::POS_W-1:0] out_position,
  output logic [sktl_pkg::ENT_W-1:0] out_entries,
  output logic                       out_full_res
);
  import sktl_pkg::*;

  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int LV  = ($clog2(TABLE_DEPTH) + 2) / 3;
  localparam int WCW = $clog2(LV + 2);

  state_t           state_r, state_nxt;
  logic [WCW-1:0]   wait_r, wait_nxt;
  logic [KEY_W-1:0] key_r;
  logic [CW-1:0]    count_r;

  logic             out_valid_r;
  logic             out_found_r;
  logic [POS_W-1:0] out_position_r;
  logic [ENT_W-1:0] out_entries_r;
  logic             out_full_r;

  logic [KEY_W-1:0] cell_key [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_lt;
  logic [TABLE_DEPTH-1:0] cell_eq;
  logic [CW-1:0]    lt_sum;
  logic             hit;
  logic             fin_go;
  logic             is_full;
  logic             ins;

  assign is_full = count_r == CW'(TABLE_DEPTH);
  assign fin_go  = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign ins     = fin_go && !hit && !is_full;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      sktl_cell #(.IDX(i), .CW(CW)) u_cell (
        .clk      (clk),
        .ins      (ins),
        .key      (key_r),
        .count    (count_r),
        .prev_key (key_r),
        .prev_lt  (1'b1),
        .key_q    (cell_key[i]),
        .lt_q     (cell_lt[i]),
        .eq_q     (cell_eq[i])
      );
    end else begin : g_rest
      sktl_cell #(.IDX(i), .CW(CW)) u_cell (
        .clk      (clk),
        .ins      (ins),
        .key      (key_r),
        .count    (count_r),
        .prev_key (cell_key[i-1]),
        .prev_lt  (cell_lt[i-1]),
        .key_q    (cell_key[i]),
        .lt_q     (cell_lt[i]),
        .eq_q     (cell_eq[i])
      );
    end
  end

  sktl_tree #(.N(TABLE_DEPTH), .LV(LV), .CW(CW)) u_tree (
    .clk (clk),
    .lt  (cell_lt),
    .eq  (cell_eq),
    .sum (lt_sum),
    .hit (hit)
  );

  always_comb begin
    state_nxt = state_r;
    wait_nxt  = wait_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_WAIT;
          wait_nxt  = WCW'(LV);
        end
      end
      S_WAIT: begin
        // waits out the cell compare register and the registered tree levels
        if (wait_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          wait_nxt = wait_r - 1'b1;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wait_r  <= wait_nxt;
      if (ins) begin
        count_r <= count_r + 1'b1;
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      key_r <= in_key;
    end
    if (fin_go) begin
      out_found_r    <= hit;
      out_full_r     <= !hit && is_full;
      out_position_r <= (!hit && is_full) ? '0 : POS_W'(lt_sum);
      out_entries_r  <= ins ? ENT_W'(count_r + 1'b1) : ENT_W'(count_r);
    end
  end

  assign in_ready     = state_r == S_IDLE;
  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;
  assign out_entries  = out_entries_r;
  assign out_full_res = out_full_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count past table depth");

  a_found_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> !out_full_res)
    else $error("found and full both set");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready again right after a key was taken");

  a_full_entries: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full_res |-> out_entries == ENT_W'(TABLE_DEPTH)
      && out_position == '0)
    else $error("full result with wrong count or position");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ins |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not bump the count");

endmodule
